[design/hdlc_deframer_bit_sync_defines.svh]
// Assertion macros for the HDLC bit-synchronizing deframer.
// Depends on a clock named clock and a synchronous reset named reset in the using module.
`ifndef HDLC_DEFRAMER_BIT_SYNC_DEFINES_SVH
`define HDLC_DEFRAMER_BIT_SYNC_DEFINES_SVH

`ifndef SYNTHESIS
`define HBS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define HBS_ASSERT_NEXT(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) cause |=> effect) \
      else $error(msg);
`else
`define HBS_ASSERT(label, prop, msg)
`define HBS_ASSERT_NEXT(label, cause, effect, msg)
`endif

`endif

[design/hbs_pkg.sv]
// Shared types and constants for the HDLC bit-synchronizing deframer.
// No dependencies.
package hbs_pkg;

   localparam int unsigned SAMPLE_W = 1;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 8;

   localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FLAG  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ABORT = 2'd2;

   localparam logic [LEN_W-1:0]  BIT_LENGTH_RESET = 8'd32;
   localparam logic [7:0]        HISTORY_RESET    = 8'h55;
   localparam logic [7:0]        EDGE_FALL        = 8'hf0;
   localparam logic [7:0]        EDGE_RISE        = 8'h0f;
   localparam logic [LEN_W:0]    RELOAD_OFFSET    = 9'd4;

   localparam logic [7:0]        STUFF_ZERO = 8'h7c;
   localparam logic [7:0]        STUFF_ONE  = 8'h7d;
   localparam logic [7:0]        FLAG_BYTE  = 8'h7e;
   localparam logic [7:0]        ABORT_BYTE = 8'h7f;

   typedef struct packed {
      logic take;
      logic value;
   } bit_type;

   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
   } result_type;

endpackage

[design/hbs_if.sv]
// Request and result channel interfaces of the HDLC bit-synchronizing deframer.
// Depends on hbs_pkg for field widths.
interface hbs_req_if;
   logic                             valid;
   logic                             ready;
   logic [hbs_pkg::SAMPLE_W-1:0]     sample_bit;

   modport source (output valid, output sample_bit, input ready);
   modport sink (input valid, input sample_bit, output ready);
endinterface

interface hbs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [hbs_pkg::KIND_W-1:0]       event_kind;
   logic [hbs_pkg::BYTE_W-1:0]       data_byte;

   modport source (output valid, output event_kind, output data_byte, input ready);
   modport sink (input valid, input event_kind, input data_byte, output ready);
endinterface

[design/hdlc_deframer_bit_sync.sv]
// HDLC bit-synchronizing deframer top level with input and result registers.
// A request is held in the input register, then its result is written to the result register once that is free.
// Throughput: one sample per cycle while the result register is not stalled.
// A request is held in the input register while the result register is stalled.
// Synchronous active-high reset clears the valid flags, resets the timing and HDLC state and sets bit_length to 32.
// Depends on hbs_pkg, hbs_if, hbs_sync, hbs_deframe and the defines header.
`include "hdlc_deframer_bit_sync_defines.svh"

module hdlc_deframer_bit_sync (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [hbs_pkg::LEN_W-1:0]  csr_write_data,
   hbs_req_if.sink                    req_chan,
   hbs_rsp_if.source                  rsp_chan
);
   import hbs_pkg::*;

   logic [LEN_W-1:0]  bit_length_ff;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic              in_bit_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [KIND_W-1:0] out_kind_ff;
   logic [BYTE_W-1:0] out_data_ff;
   logic              out_free;
   logic              fire;
   bit_type           strobe;
   result_type        result;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || fire;

   assign in_valid_in  = req_chan.valid || (in_valid_ff && !fire);
   assign out_valid_in = fire ? result.valid : (out_valid_ff && !rsp_chan.ready);

   hbs_sync u_sync (
      .clock      (clock),
      .reset      (reset),
      .advance    (fire),
      .sample     (in_bit_ff),
      .bit_length (bit_length_ff),
      .strobe     (strobe)
   );

   hbs_deframe u_deframe (
      .clock  (clock),
      .reset  (reset),
      .strobe (strobe),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_length_ff <= BIT_LENGTH_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            bit_length_ff <= csr_write_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_bit_ff <= req_chan.sample_bit[0];
      end
      if (fire && result.valid) begin
         out_kind_ff <= result.kind;
         out_data_ff <= result.data;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.event_kind = out_kind_ff;
   assign rsp_chan.data_byte  = out_data_ff;

   `HBS_ASSERT(a_marker_no_data, (out_valid_ff && out_kind_ff != KIND_DATA) |-> (out_data_ff == '0), "Flag or abort result carries a nonzero data byte.")
   `HBS_ASSERT(a_kind_legal, out_valid_ff |-> (out_kind_ff == KIND_DATA || out_kind_ff == KIND_FLAG || out_kind_ff == KIND_ABORT), "Result carries an undefined event kind.")
   `HBS_ASSERT(a_stall_cause, !req_chan.ready |-> (in_valid_ff && out_valid_ff && !rsp_chan.ready), "Request stalled without a blocked result.")
   `HBS_ASSERT_NEXT(a_result_lands, (fire && result.valid), out_valid_ff, "Produced result did not reach the result register.")

endmodule

[design/hbs_sync.sv]
// Bit timing recovery: sample history, transition detection and sample counter.
// Depends on hbs_pkg.
module hbs_sync (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       sample,
   input  logic [hbs_pkg::LEN_W-1:0]  bit_length,
   output hbs_pkg::bit_type           strobe
);
   import hbs_pkg::*;

   logic [7:0]       history_ff;
   logic [7:0]       history_in;
   logic [LEN_W-1:0] counter_ff;
   logic [LEN_W-1:0] counter_in;
   logic [LEN_W:0]   next_count;
   logic             reload;
   logic             take;

   assign history_in = {history_ff[6:0], sample};
   assign reload     = (history_in == EDGE_FALL) || (history_in == EDGE_RISE);
   assign next_count = reload ? ({1'b0, bit_length >> 1} + RELOAD_OFFSET)
                              : ({1'b0, counter_ff} + {{LEN_W{1'b0}}, 1'b1});
   assign take       = next_count >= {1'b0, bit_length};
   assign counter_in = take ? '0 : next_count[LEN_W-1:0];

   assign strobe.take  = advance && take;
   assign strobe.value = sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= HISTORY_RESET;
         counter_ff <= '0;
      end else if (advance) begin
         history_ff <= history_in;
         counter_ff <= counter_in;
      end
   end

endmodule

[design/hbs_deframe.sv]
// HDLC bit handling: zero destuffing, flag and abort detection, byte assembly.
// Depends on hbs_pkg.
module hbs_deframe (
   input  logic                clock,
   input  logic                reset,
   input  hbs_pkg::bit_type    strobe,
   output hbs_pkg::result_type result
);
   import hbs_pkg::*;

   logic [7:0]        bits_ff;
   logic [7:0]        bits_in;
   logic [7:0]        marks_ff;
   logic [7:0]        marks_in;
   logic [BYTE_W-1:0] shift_ff;
   logic [BYTE_W-1:0] shift_in;
   logic [2:0]        count_ff;
   logic [2:0]        count_in;
   logic [7:0]        bits_next;
   logic              is_stuff;
   logic              is_flag;
   logic              is_abort;

   assign bits_next = {bits_ff[6:0], strobe.value};
   assign is_stuff  = (bits_next == STUFF_ZERO) || (bits_next == STUFF_ONE);
   assign is_flag   = bits_next == FLAG_BYTE;
   assign is_abort  = bits_next == ABORT_BYTE;

   always_comb begin
      bits_in  = bits_ff;
      marks_in = marks_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      result   = '0;
      if (strobe.take) begin
         bits_in  = bits_next;
         marks_in = {marks_ff[6:0], 1'b1};
         if (is_stuff) begin
            marks_in[1] = 1'b0;
         end
         if (is_flag || is_abort) begin
            marks_in     = '0;
            count_in     = '0;
            result.valid = 1'b1;
            result.kind  = is_flag ? KIND_FLAG : KIND_ABORT;
         end else if (marks_in[7]) begin
            shift_in = {shift_ff[BYTE_W-2:0], bits_next[7]};
            count_in = count_ff + 3'd1;
            if (count_ff == 3'd7) begin
               result.valid = 1'b1;
               result.kind  = KIND_DATA;
               result.data  = shift_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= '0;
         marks_ff <= '0;
         shift_ff <= '0;
         count_ff <= '0;
      end else begin
         bits_ff  <= bits_in;
         marks_ff <= marks_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
      end
   end

endmodule

[bench/hdlc_deframer_bit_sync_tb.sv]
// Self-checking testbench for the HDLC bit-synchronizing deframer.
// Drives oversampled HDLC line bits, predicts flag, abort and data events, and checks each one.
// Depends on hbs_pkg, the hbs_req_if and hbs_rsp_if interfaces and hdlc_deframer_bit_sync.
`timescale 1ns / 1ps

module hdlc_deframer_bit_sync_tb;
   import hbs_pkg::*;

   localparam int MAX_GAP      = 14;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 800000;
   localparam int ITEM_TARGET  = 1450;
   localparam int LONG_HOLD    = 300;
   localparam logic [22:0] DIRECTED_BITS = 23'b01111110_1111101_01111111;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
   } frame_event_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_write_enable;
   logic [LEN_W-1:0] csr_write_data;

   hbs_req_if req();
   hbs_rsp_if rsp();

   hdlc_deframer_bit_sync DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req),
      .rsp_chan         (rsp)
   );

   always #5 clock = ~clock;

   logic [LEN_W-1:0] bit_length;
   logic [7:0]       sample_hist;
   logic [7:0]       sample_count;
   logic [7:0]       bit_hist;
   logic [7:0]       valid_marks;
   logic [7:0]       byte_shift;
   logic [3:0]       bits_in_byte;

   frame_event_type pending_events[$];
   bit              line_bits[$];
   int              mismatches = 0;
   int              samples_sent = 0;
   int              events_seen = 0;
   int              phase_left = 0;
   int              cycles = 0;
   int              hold_request = 0;
   int              ones_run = 0;
   bit              sender_gaps = 1'b1;
   bit              receiver_stalls = 1'b1;

   task automatic reset_predictor();
      bit_length   = BIT_LENGTH_RESET;
      sample_hist  = HISTORY_RESET;
      sample_count = '0;
      bit_hist     = '0;
      valid_marks  = '0;
      byte_shift   = '0;
      bits_in_byte = '0;
   endtask

   function automatic bit take_line_bit(input logic b, output frame_event_type ev);
      ev = '0;
      bit_hist    = {bit_hist[6:0], b};
      valid_marks = {valid_marks[6:0], 1'b1};
      if (bit_hist == STUFF_ZERO || bit_hist == STUFF_ONE) begin
         valid_marks[1] = 1'b0;
      end else if (bit_hist == FLAG_BYTE || bit_hist == ABORT_BYTE) begin
         ev.kind      = (bit_hist == FLAG_BYTE) ? KIND_FLAG : KIND_ABORT;
         valid_marks  = '0;
         bits_in_byte = '0;
         return 1'b1;
      end
      if (valid_marks[7]) begin
         byte_shift   = {byte_shift[6:0], bit_hist[7]};
         bits_in_byte = bits_in_byte + 4'd1;
         if (bits_in_byte >= 4'd8) begin
            bits_in_byte = '0;
            ev.kind      = KIND_DATA;
            ev.data      = byte_shift;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit decode_sample(input logic b, output frame_event_type ev);
      logic [LEN_W:0] next_count;
      ev = '0;
      sample_hist = {sample_hist[6:0], b};
      if (sample_hist == EDGE_FALL || sample_hist == EDGE_RISE) begin
         next_count = {1'b0, bit_length >> 1} + RELOAD_OFFSET;
      end else begin
         next_count = {1'b0, sample_count} + 9'd1;
      end
      if (next_count < {1'b0, bit_length}) begin
         sample_count = next_count[LEN_W-1:0];
         return 1'b0;
      end
      sample_count = '0;
      return take_line_bit(b, ev);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in event %0d: %s got %0d expected %0d", events_seen, what, got, want);
      mismatches++;
   endtask

   task automatic send_sample(input logic b);
      int              gap;
      frame_event_type ev;
      gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid      <= 1'b1;
      req.sample_bit <= b;
      do @(posedge clock); while (req.ready !== 1'b1);
      if (decode_sample(b, ev)) pending_events.push_back(ev);
      samples_sent++;
      if (phase_left > 0) phase_left--;
   endtask

   task automatic wait_for_events();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_bit_length(input logic [LEN_W-1:0] value);
      wait_for_events();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      bit_length = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic push_raw(input logic [7:0] value);
      for (int i = 7; i >= 0; i--) line_bits.push_back(value[i]);
   endtask

   task automatic push_stuffed(input logic [7:0] value);
      for (int i = 7; i >= 0; i--) begin
         line_bits.push_back(value[i]);
         ones_run = value[i] ? ones_run + 1 : 0;
         if (ones_run == 5) begin
            line_bits.push_back(1'b0);
            ones_run = 0;
         end
      end
   endtask

   task automatic build_frame();
      int count;
      line_bits.delete();
      push_raw(FLAG_BYTE);
      ones_run = 0;
      count = $urandom_range(1, 4);
      repeat (count) begin
         if ($urandom_range(0, 3) == 0) push_stuffed(8'hff);
         else push_stuffed(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 4) == 0) push_raw(ABORT_BYTE);
      else push_raw(FLAG_BYTE);
   endtask

   task automatic send_line_bits(input bit noisy);
      int   spb;
      int   count;
      logic s;
      spb = (bit_length < 2) ? 1 : bit_length;
      foreach (line_bits[i]) begin
         if (phase_left == 0) return;
         count = spb;
         if (spb > 2 && $urandom_range(0, 7) == 0) begin
            count = ($urandom_range(0, 1) != 0) ? spb + 1 : spb - 1;
         end
         repeat (count) begin
            s = line_bits[i];
            if (noisy && $urandom_range(0, 99) == 0) s = ~s;
            send_sample(s);
         end
      end
   endtask

   task automatic run_frames(input int budget);
      int count;
      phase_left = budget;
      while (phase_left > 0) begin
         if ($urandom_range(0, 5) == 0) begin
            count = $urandom_range(4, 20);
            repeat (count) send_sample($urandom_range(0, 1) != 0);
         end else begin
            build_frame();
            send_line_bits(1'b1);
         end
         sender_gaps = ($urandom_range(0, 2) != 0);
      end
   endtask

   task automatic test_reset_length();
      line_bits.delete();
      push_raw(FLAG_BYTE);
      phase_left = 400;
      send_line_bits(1'b0);
   endtask

   task automatic test_directed();
      write_bit_length(8'd0);
      for (int i = 22; i >= 0; i--) send_sample(DIRECTED_BITS[i]);
   endtask

   task automatic test_one_sample_bits();
      write_bit_length(8'd1);
      run_frames(150);
   endtask

   task automatic test_reload_boundary();
      write_bit_length(8'd8);
      run_frames(120);
      write_bit_length(8'd9);
      run_frames(100);
   endtask

   task automatic test_receiver_hold();
      write_bit_length(8'd1);
      sender_gaps  = 1'b0;
      hold_request = LONG_HOLD;
      repeat (3) begin
         build_frame();
         phase_left = 1000;
         send_line_bits(1'b0);
      end
   endtask

   task automatic test_sender_pause();
      write_bit_length(8'd10);
      run_frames(100);
      wait_for_events();
      run_frames(100);
   endtask

   task automatic test_long_bits();
      write_bit_length(8'd255);
      run_frames(200);
      // The counter is usually above the new length here, so a bit is taken on the next sample.
      write_bit_length(8'd8);
      run_frames(100);
   endtask

   task automatic test_random_lengths();
      int               pick;
      logic [LEN_W-1:0] len_choice;
      while (samples_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) len_choice = LEN_W'($urandom_range(8, 16));
         else if (pick == 7) len_choice = LEN_W'($urandom_range(0, 1));
         else if (pick == 8) len_choice = LEN_W'($urandom_range(17, 64));
         else len_choice = LEN_W'($urandom_range(200, 255));
         write_bit_length(len_choice);
         run_frames(120);
      end
   endtask

   initial begin
      int gap;
      rsp.ready = 1'b0;
      forever begin
         if (hold_request > 0) begin
            gap = hold_request;
            hold_request = 0;
         end else begin
            gap = receiver_stalls ? $urandom_range(0, MAX_GAP) : 0;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (rsp.valid !== 1'b1);
         if ($urandom_range(0, 15) == 0) receiver_stalls = !receiver_stalls;
      end
   end

   always @(posedge clock) begin : check_events
      frame_event_type want;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         events_seen++;
         if (pending_events.size() == 0) begin
            report_mismatch("event with nothing expected, kind", rsp.event_kind, -1);
         end else begin
            want = pending_events.pop_front();
            if (rsp.event_kind !== want.kind) begin
               report_mismatch("event_kind", rsp.event_kind, want.kind);
            end
            if (rsp.data_byte !== want.data) begin
               report_mismatch("data_byte", rsp.data_byte, want.data);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("hdlc_deframer_bit_sync_tb failed");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req.valid        = 1'b0;
      req.sample_bit   = '0;
      reset_predictor();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_length();
      test_directed();
      test_one_sample_bits();
      test_reload_boundary();
      test_receiver_hold();
      test_sender_pause();
      test_long_bits();
      test_random_lengths();

      wait_for_events();
      if (mismatches == 0 && pending_events.size() == 0) begin
         $display("hdlc_deframer_bit_sync_tb passed");
      end else begin
         $display("hdlc_deframer_bit_sync_tb failed");
      end
      $finish;
   end

endmodule
